@@ hw/rtl/jls_pkg.sv @@
package jls_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ROW_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int TOL_W     = 31;
  localparam int ITER_W    = 10;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 31;

  localparam int DEF_MAX_UNKNOWNS = 16;

  localparam logic [1:0] REQ_COEF  = 2'd0;
  localparam logic [1:0] REQ_RHS   = 2'd1;
  localparam logic [1:0] REQ_GUESS = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TOL   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MAXIT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RST  = 5'd1;
  localparam logic [TOL_W-1:0]  TOL_RST   = 31'd66;
  localparam logic [ITER_W-1:0] MAXIT_RST = 10'd100;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         index;
    logic signed [DATA_W-1:0] solution_value;
    logic [ITER_W-1:0]        iterations;
    logic                     converged;
    logic                     zero_pivot;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
    logic dot_rd;
    logic dot_mul;
    logic dot_acc;
    logic div_init;
    logic div_step;
    logic wr_next;
    logic cpy_chk;
    logic sweep_next;
    logic sweep_done;
    logic out_ld;
    logic out_adv;
  } ctl_cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic div_last;
    logic ok;
    logic it_last;
  } ctl_stat_t;

  function automatic logic [DATA_W-1:0] mag_q(logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

endpackage

@@ hw/rtl/jls_ctrl.sv @@
module jls_ctrl import jls_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req,
  input  logic       out_stall,
  input  ctl_stat_t  stat,
  output ctl_cmd_t   cmd,
  output logic       in_stall,
  output logic       out_valid
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_DOT_RD   = 4'd2;
  localparam logic [3:0] S_DOT_MUL  = 4'd3;
  localparam logic [3:0] S_DOT_ACC  = 4'd4;
  localparam logic [3:0] S_DIV_INIT = 4'd5;
  localparam logic [3:0] S_DIV      = 4'd6;
  localparam logic [3:0] S_WR_NEXT  = 4'd7;
  localparam logic [3:0] S_CPY_RD   = 4'd8;
  localparam logic [3:0] S_CPY_CHK  = 4'd9;
  localparam logic [3:0] S_SWEEP    = 4'd10;
  localparam logic [3:0] S_OUT_RD   = 4'd11;
  localparam logic [3:0] S_OUT_LD   = 4'd12;
  localparam logic [3:0] S_OUT_WAIT = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT_WAIT);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req == REQ_START) begin
            state_nxt = S_START;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_DOT_RD;
      end
      S_DOT_RD: begin
        cmd.dot_rd = 1'b1;
        state_nxt = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        cmd.dot_mul = 1'b1;
        state_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        cmd.dot_acc = 1'b1;
        state_nxt = stat.j_last ? S_DIV_INIT : S_DOT_RD;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_WR_NEXT;
      end
      S_WR_NEXT: begin
        cmd.wr_next = 1'b1;
        state_nxt = stat.i_last ? S_CPY_RD : S_DOT_RD;
      end
      S_CPY_RD: begin
        state_nxt = S_CPY_CHK;
      end
      S_CPY_CHK: begin
        cmd.cpy_chk = 1'b1;
        state_nxt = stat.i_last ? S_SWEEP : S_CPY_RD;
      end
      S_SWEEP: begin
        if (stat.ok || stat.it_last) begin
          cmd.sweep_done = 1'b1;
          state_nxt = S_OUT_RD;
        end else begin
          cmd.sweep_next = 1'b1;
          state_nxt = S_DOT_RD;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (!out_stall) begin
          cmd.out_adv = 1'b1;
          state_nxt = stat.i_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/jls_dpath.sv @@
module jls_dpath import jls_pkg::*; #(
  parameter int MAX_UNKNOWNS = DEF_MAX_UNKNOWNS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  in_item_t          in_item,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         stat,
  output out_item_t         out_item
);

  localparam int IW    = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int DEPTH = MAX_UNKNOWNS * MAX_UNKNOWNS;
  localparam int CAW   = $clog2(DEPTH);
  localparam int ACC_W = DATA_W + IW + 1;
  localparam int NUM_W = ACC_W + 1;
  localparam int QW    = NUM_W + FRAC_BITS;
  localparam int CW    = $clog2(QW);
  localparam int PW    = 2 * DATA_W;

  localparam logic [QW-1:0] Q_MAX = QW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [QW-1:0] Q_MIN = QW'({1'b1, {(DATA_W-1){1'b0}}});
  localparam logic [PW-FRAC_BITS-1:0] P_MAX = (PW-FRAC_BITS)'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [PW-FRAC_BITS-1:0] P_MIN = (PW-FRAC_BITS)'({1'b1, {(DATA_W-1){1'b0}}});
  localparam logic signed [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [SIZE_W-1:0] size_r;
  logic [TOL_W-1:0]  tol_r;
  logic [ITER_W-1:0] maxit_r;

  logic signed [DATA_W-1:0] coef_mem [DEPTH];
  logic signed [DATA_W-1:0] rhs_mem  [MAX_UNKNOWNS];
  logic signed [DATA_W-1:0] sol_mem  [MAX_UNKNOWNS];
  logic signed [DATA_W-1:0] nxt_mem  [MAX_UNKNOWNS];
  logic [MAX_UNKNOWNS-1:0]  sol_vld_r;

  logic signed [DATA_W-1:0] coef_rd_r, rhs_rd_r, sol_rd_r, nxt_rd_r;

  logic [IW-1:0]            i_r, j_r, n_m1;
  logic [ITER_W-1:0]        it_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [PW-1:0]            prod_r;
  logic                     neg_r;
  logic signed [DATA_W-1:0] diag_r;
  logic                     zp_r, ok_r, conv_r;
  logic                     num_neg_r, num_nz_r;
  logic [QW-1:0]            dvd_r, q_r;
  logic [DATA_W-1:0]        rem_r;
  logic [CW-1:0]            cnt_r;
  out_item_t                out_r;

  logic                     ld_ok, ld_col_ok;
  logic [IW-1:0]            ld_row;
  logic [CAW-1:0]           ld_caddr, rd_caddr;
  logic [IW-1:0]            sol_raddr;
  logic [PW-FRAC_BITS-1:0]  pm;
  logic signed [DATA_W-1:0] term;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         num_mag;
  logic [DATA_W:0]          rem_sh;
  logic                     q_bit;
  logic signed [DATA_W-1:0] q_sat;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          diff_mag;

  always_comb begin
    if (size_r == '0) begin
      n_m1 = '0;
    end else if (32'(size_r) > MAX_UNKNOWNS) begin
      n_m1 = IW'(MAX_UNKNOWNS - 1);
    end else begin
      n_m1 = IW'(32'(size_r) - 1);
    end
  end

  assign stat.j_last   = (j_r == n_m1);
  assign stat.i_last   = (i_r == n_m1);
  assign stat.div_last = (cnt_r == '0);
  assign stat.ok       = ok_r;
  assign stat.it_last  = (it_r == maxit_r);

  assign ld_ok     = cmd.load && (32'(in_item.row) < MAX_UNKNOWNS);
  assign ld_col_ok = (32'(in_item.col) < MAX_UNKNOWNS);
  assign ld_row    = IW'(32'(in_item.row));
  assign ld_caddr  = CAW'(32'(in_item.row) * MAX_UNKNOWNS + 32'(in_item.col));
  assign rd_caddr  = CAW'(32'(i_r) * MAX_UNKNOWNS + 32'(j_r));
  assign sol_raddr = cmd.dot_rd ? j_r : i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RST;
      tol_r   <= TOL_RST;
      maxit_r <= MAXIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SIZE:  size_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_TOL:   tol_r   <= cfg_wdata[TOL_W-1:0];
        CFG_MAXIT: maxit_r <= cfg_wdata[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ok && ld_col_ok && in_item.req_type == REQ_COEF) begin
      coef_mem[ld_caddr] <= in_item.value;
    end
    coef_rd_r <= coef_mem[rd_caddr];
  end

  always_ff @(posedge clk) begin
    if (ld_ok && in_item.req_type == REQ_RHS) begin
      rhs_mem[ld_row] <= in_item.value;
    end
    rhs_rd_r <= rhs_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_next) begin
      nxt_mem[i_r] <= q_sat;
    end
    nxt_rd_r <= nxt_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (ld_ok && in_item.req_type == REQ_GUESS) begin
      sol_mem[ld_row] <= in_item.value;
    end else if (cmd.cpy_chk) begin
      sol_mem[i_r] <= nxt_rd_r;
    end
    sol_rd_r <= sol_vld_r[sol_raddr] ? sol_mem[sol_raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sol_vld_r <= '0;
    end else if (ld_ok && in_item.req_type == REQ_GUESS) begin
      sol_vld_r[ld_row] <= 1'b1;
    end else if (cmd.cpy_chk) begin
      sol_vld_r[i_r] <= 1'b1;
    end
  end

  always_comb begin
    pm = prod_r[PW-1:FRAC_BITS];
    if (neg_r) begin
      term = (pm > P_MIN) ? V_MIN : -DATA_W'(pm);
    end else begin
      term = (pm > P_MAX) ? V_MAX : DATA_W'(pm);
    end
  end

  always_comb begin
    num     = NUM_W'(rhs_rd_r) - NUM_W'(acc_r);
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rem_sh  = {rem_r, dvd_r[QW-1]};
    q_bit   = (rem_sh >= {1'b0, mag_q(diag_r)});
  end

  always_comb begin
    if (diag_r == '0) begin
      q_sat = !num_nz_r ? '0 : (num_neg_r ? V_MIN : V_MAX);
    end else if (num_neg_r ^ diag_r[DATA_W-1]) begin
      q_sat = (q_r > Q_MIN) ? V_MIN : -DATA_W'(q_r);
    end else begin
      q_sat = (q_r > Q_MAX) ? V_MAX : DATA_W'(q_r);
    end
  end

  always_comb begin
    diff     = (DATA_W+1)'(nxt_rd_r) - (DATA_W+1)'(sol_rd_r);
    diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      j_r    <= '0;
      it_r   <= '0;
      zp_r   <= 1'b0;
      ok_r   <= 1'b1;
      conv_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cmd.start) begin
        i_r  <= '0;
        j_r  <= '0;
        it_r <= '0;
        zp_r <= 1'b0;
        ok_r <= 1'b1;
      end
      if (cmd.dot_mul && i_r == j_r && coef_rd_r == '0) zp_r <= 1'b1;
      if (cmd.dot_acc) j_r <= stat.j_last ? '0 : j_r + 1'b1;
      if (cmd.div_init) cnt_r <= CW'(QW - 1);
      if (cmd.div_step) cnt_r <= cnt_r - 1'b1;
      if (cmd.wr_next || cmd.cpy_chk || cmd.out_adv) begin
        i_r <= stat.i_last ? '0 : i_r + 1'b1;
      end
      if (cmd.cpy_chk && diff_mag > (DATA_W+1)'(tol_r)) ok_r <= 1'b0;
      if (cmd.sweep_next) begin
        it_r <= it_r + 1'b1;
        ok_r <= 1'b1;
      end
      if (cmd.sweep_done) conv_r <= ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.wr_next) acc_r <= '0;
    else if (cmd.dot_acc && i_r != j_r) acc_r <= acc_r + ACC_W'(term);
    if (cmd.dot_mul) begin
      prod_r <= PW'(mag_q(coef_rd_r)) * PW'(mag_q(sol_rd_r));
      neg_r  <= coef_rd_r[DATA_W-1] ^ sol_rd_r[DATA_W-1];
      if (i_r == j_r) diag_r <= coef_rd_r;
    end
    if (cmd.div_init) begin
      num_neg_r <= num[NUM_W-1];
      num_nz_r  <= (num != '0);
      dvd_r     <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_r     <= '0;
      q_r       <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], q_bit};
      rem_r <= q_bit ? DATA_W'(rem_sh - {1'b0, mag_q(diag_r)}) : DATA_W'(rem_sh);
    end
    if (cmd.out_ld) begin
      out_r.index          <= ROW_W'(32'(i_r));
      out_r.solution_value <= sol_rd_r;
      out_r.iterations     <= it_r;
      out_r.converged      <= conv_r;
      out_r.zero_pivot     <= zp_r;
      out_r.last           <= stat.i_last;
    end
  end

  assign out_item = out_r;

endmodule

@@ hw/rtl/jacobi_linear_solver.sv @@
// Jacobi solver for A x = b in signed Q16.16. Load items (coefficient, rhs,
// initial guess) are taken one per cycle. A start item holds the input
// stalled while sweeps run on one shared multiplier and a bit-serial restoring
// divider (QW = 38 + FRAC bits of quotient at default size). The run then
// emits n items, holding each while out_stall is high. The solution is kept as
// the next initial guess.
module jacobi_linear_solver import jls_pkg::*; #(
  parameter int MAX_UNKNOWNS = DEF_MAX_UNKNOWNS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  jls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_item.req_type),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  jls_dpath #(
    .MAX_UNKNOWNS (MAX_UNKNOWNS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while emitting");

  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.req_type == REQ_START |=> in_stall && !out_valid)
    else $error("start item did not begin a solve");

  a_gap_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid) else $error("result item repeated");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.last |=> !in_stall)
    else $error("solver busy after last item");
`endif

endmodule

@@ verif/jls_checker.sv @@
module jls_checker import jls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_item,
  output int                mismatches,
  output int                pending,
  output int                results_seen
);

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  longint coef_m [256];
  longint rhs_v [16];
  longint x_v [16];
  logic [SIZE_W-1:0] n_reg;
  logic [TOL_W-1:0]  tol_reg;
  logic [ITER_W-1:0] maxit_reg;
  out_item_t solution_q[$];

  initial begin
    mismatches = 0;
    pending = 0;
    results_seen = 0;
  end

  function automatic longint sat_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint unsigned abs_q(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint mul_fix(longint a, longint b);
    logic neg;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    m = (abs_q(a) * abs_q(b)) >> FRAC_BITS;
    return sat_q(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint div_fix(longint num, longint den);
    logic neg;
    longint unsigned q;
    if (den == 0) return num > 0 ? QMAX : (num < 0 ? QMIN : 0);
    neg = (num < 0) != (den < 0);
    q = (abs_q(num) << FRAC_BITS) / abs_q(den);
    return sat_q(neg ? -longint'(q) : longint'(q));
  endfunction

  task automatic solve_sweeps();
    int n;
    int stop_it;
    logic conv;
    logic zp;
    logic ok;
    longint acc;
    longint nxt [16];
    out_item_t r;
    n = (n_reg == 0) ? 1 : (n_reg > 16 ? 16 : int'(n_reg));
    conv = 0;
    zp = 0;
    stop_it = 0;
    for (int i = 0; i < n; i++) if (coef_m[i*16+i] == 0) zp = 1;
    for (int it = 0; it <= int'(maxit_reg); it++) begin
      ok = 1;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) if (j != i) acc += mul_fix(coef_m[i*16+j], x_v[j]);
        nxt[i] = div_fix(rhs_v[i] - acc, coef_m[i*16+i]);
      end
      for (int i = 0; i < n; i++) begin
        if (abs_q(nxt[i] - x_v[i]) > longint'(tol_reg)) ok = 0;
        x_v[i] = nxt[i];
      end
      stop_it = it;
      if (ok) begin
        conv = 1;
        break;
      end
    end
    for (int k = 0; k < n; k++) begin
      r.index = ROW_W'(k);
      r.solution_value = DATA_W'(x_v[k]);
      r.iterations = ITER_W'(stop_it);
      r.converged = conv;
      r.zero_pivot = zp;
      r.last = (k == n - 1);
      solution_q.push_back(r);
    end
  endtask

  always @(negedge clk) begin : watch
    out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 256; i++) coef_m[i] = 0;
      for (int i = 0; i < 16; i++) begin
        rhs_v[i] = 0;
        x_v[i] = 0;
      end
      n_reg = SIZE_RST;
      tol_reg = TOL_RST;
      maxit_reg = MAXIT_RST;
      solution_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SIZE:  n_reg = cfg_wdata[SIZE_W-1:0];
          CFG_TOL:   tol_reg = cfg_wdata[TOL_W-1:0];
          CFG_MAXIT: maxit_reg = cfg_wdata[ITER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_item.req_type)
          REQ_COEF:  coef_m[in_item.row*16 + in_item.col] = $signed(in_item.value);
          REQ_RHS:   rhs_v[in_item.row] = $signed(in_item.value);
          REQ_GUESS: x_v[in_item.row] = $signed(in_item.value);
          default:   solve_sweeps();
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (solution_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", out_item);
        end else begin
          exp_r = solution_q.pop_front();
          if (out_item !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", exp_r, out_item);
          end
        end
      end
    end
    pending = solution_q.size();
  end

endmodule

@@ verif/tb_jacobi_linear_solver.sv @@
module tb_jacobi_linear_solver;
  import jls_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int ITEM_GOAL = 420;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  int mismatches;
  int pending;
  int results_seen;

  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int cur_n = 1;
  bit coef_wr [16][16];
  bit rhs_wr [16];

  jacobi_linear_solver uut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item
  );

  jls_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .mismatches, .pending, .results_seen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // long receiver hold-off once results are flowing
  always @(posedge clk) begin
    if (!hold_done && results_seen >= 20) begin
      hold_cnt <= 600;
      hold_done <= 1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin : rx_pattern
    logic s;
    s = 0;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: s = 0;
      1: s = ($urandom_range(0, 3) == 0);
      2: s = ($urandom_range(0, 3) != 0);
      default: s = ~out_stall;
    endcase
    out_stall <= (hold_cnt != 0) | s;
  end

  task automatic send(input in_item_t it);
    int gap;
    logic go;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    items_sent++;
  endtask

  task automatic load(input logic [1:0] rt, input int r, input int c, input logic [31:0] v);
    in_item_t it;
    it.req_type = rt;
    it.row = ROW_W'(r);
    it.col = ROW_W'(c);
    it.value = v;
    if (rt == REQ_COEF) coef_wr[r][c] = 1;
    if (rt == REQ_RHS) rhs_wr[r] = 1;
    send(it);
  endtask

  task automatic set_cfg(input int sz, input logic [TOL_W-1:0] tol, input int mi);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_SIZE;
    cfg_wdata <= CFG_DW'(sz);
    @(posedge clk);
    cfg_addr <= CFG_TOL;
    cfg_wdata <= CFG_DW'(tol);
    @(posedge clk);
    cfg_addr <= CFG_MAXIT;
    cfg_wdata <= CFG_DW'(mi);
    @(posedge clk);
    cfg_addr <= CFG_NONE;
    cfg_wdata <= CFG_DW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_n = (sz == 0) ? 1 : (sz > 16 ? 16 : sz);
  endtask

  function automatic logic [31:0] off_val();
    return ($urandom_range(0, 9) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
  endfunction

  function automatic logic [31:0] diag_val(input int n);
    int m;
    m = n * 32'h4000 + 32'h10000 + $urandom_range(0, 32'h40000);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return $urandom_range(0, 1) ? 32'(m) : 32'(-m);
  endfunction

  function automatic logic [31:0] vec_val();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h1000000)) - 32'sh800000);
  endfunction

  task automatic fill_unwritten();
    for (int i = 0; i < cur_n; i++) begin
      if (!rhs_wr[i]) load(REQ_RHS, i, 0, vec_val());
      for (int j = 0; j < cur_n; j++)
        if (!coef_wr[i][j]) load(REQ_COEF, i, j, (i == j) ? diag_val(cur_n) : off_val());
    end
  endtask

  task automatic start_solve();
    fill_unwritten();
    load(REQ_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
  endtask

  initial begin
    int sz;
    int mi;
    int nl;
    int r;
    int c;
    logic [TOL_W-1:0] tol;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two unknowns, zero diagonal, oscillates until the iteration limit
    set_cfg(2, '0, 1023);
    load(REQ_COEF, 0, 0, 32'h0);
    load(REQ_COEF, 0, 1, 32'h10000);
    load(REQ_COEF, 1, 0, 32'h10000);
    load(REQ_COEF, 1, 1, 32'h0);
    load(REQ_RHS, 0, 0, 32'h0);
    load(REQ_RHS, 1, 0, 32'h0);
    load(REQ_GUESS, 0, 0, 32'h10000);
    load(REQ_GUESS, 1, 0, 32'h0);
    start_solve();
    // size zero acts as one, loosest tolerance, single sweep
    set_cfg(0, '1, 0);
    load(REQ_COEF, 0, 0, 32'h80000000);
    load(REQ_RHS, 0, 0, 32'h7FFFFFFF);
    start_solve();
    load(REQ_COEF, 0, 0, 32'h1);
    load(REQ_RHS, 0, 0, 32'h80000000);
    load(REQ_GUESS, 15, 15, 32'hFFFFFFFF);
    start_solve();
    load(REQ_RHS, 0, 0, 32'h0);
    load(REQ_COEF, 0, 0, 32'h0);
    start_solve();
    // oversized setting acts as the full matrix
    set_cfg(31, 31'd66, 2);
    start_solve();

    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: sz = 0;
          1: sz = 16;
          2: sz = $urandom_range(17, 31);
          default: sz = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 4))
          0: tol = '0;
          1: tol = '1;
          2: tol = $urandom;
          default: tol = $urandom_range(0, 2000);
        endcase
        mi = $urandom_range(0, 60);
        if (sz == 0 || sz >= 8) mi = $urandom_range(0, 6);
        set_cfg(sz, tol, mi);
      end
      nl = $urandom_range(1, 2 * cur_n + 2);
      for (int k = 0; k < nl; k++) begin
        r = $urandom_range(0, cur_n - 1);
        c = $urandom_range(0, cur_n - 1);
        case ($urandom_range(0, 7))
          0: load(REQ_RHS, r, 0, vec_val());
          1: load(REQ_GUESS, r, $urandom_range(0, 15), vec_val());
          2: load(2'($urandom_range(0, 2)), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom);
          default: load(REQ_COEF, r, c, (r == c) ? diag_val(cur_n) : off_val());
        endcase
      end
      start_solve();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
